>>> hdl/ssaw_pkg.sv
// Package for the selective-repeat sender window: register indexes, status
// codes, field widths and reset values. Used by every file under hdl/.
package ssaw_pkg;

    localparam int WINDOW_SLOTS_DEF = 16;

    localparam int COUNT_W = 32;   // fragment_count, indexes, window base
    localparam int FBYTES_W = 16;  // fragment_bytes
    localparam int TBYTES_W = 31;  // total_bytes and acked byte count
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_FRAGMENT_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAGMENT_BYTES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_BYTES = 2'd2;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_ACK = 1'b1;

    localparam logic [1:0] STATUS_DROPPED = 2'd0;
    localparam logic [1:0] STATUS_ACCEPTED = 2'd1;
    localparam logic [1:0] STATUS_COMPLETE = 2'd2;
    localparam logic [1:0] STATUS_STARTED = 2'd3;

    localparam logic [FBYTES_W-1:0] FRAGMENT_BYTES_RST = 16'd1024;
    localparam logic [TBYTES_W-1:0] BYTES_MAX = {TBYTES_W{1'b1}};

endpackage

>>> hdl/ssaw_rem_unit.sv
// Iterative remainder unit: total_bytes mod fragment_bytes, one quotient
// bit per cycle (restoring). Depends on ssaw_pkg for field widths.
module ssaw_rem_unit
    import ssaw_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [TBYTES_W-1:0] dividend,
    input  logic [FBYTES_W-1:0] divisor,
    output logic                busy,
    output logic [FBYTES_W-1:0] remainder
);

    localparam int STEP_W = $clog2(TBYTES_W + 1);

    logic [STEP_W-1:0]   step_reg, step_next;
    logic [TBYTES_W-1:0] dvd_reg, dvd_next;
    logic [FBYTES_W-1:0] dvs_reg, dvs_next;
    logic [FBYTES_W-1:0] rem_reg, rem_next;
    logic [FBYTES_W:0]   trial;

    always_comb
    begin
        step_next = step_reg;
        dvd_next = dvd_reg;
        dvs_next = dvs_reg;
        rem_next = rem_reg;
        trial = {rem_reg, dvd_reg[TBYTES_W-1]};
        if (start)
        begin
            step_next = STEP_W'(TBYTES_W);
            dvd_next = dividend;
            dvs_next = divisor;
            rem_next = '0;
        end
        else if (step_reg != '0)
        begin
            // partial remainder stays below the divisor, so it fits 16 bits
            if (trial >= {1'b0, dvs_reg})
                rem_next = FBYTES_W'(trial - {1'b0, dvs_reg});
            else
                rem_next = trial[FBYTES_W-1:0];
            dvd_next = {dvd_reg[TBYTES_W-2:0], 1'b0};
            step_next = step_reg - STEP_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            dvd_reg <= '0;
            dvs_reg <= '0;
            rem_reg <= '0;
        end
        else
        begin
            step_reg <= step_next;
            dvd_reg <= dvd_next;
            dvs_reg <= dvs_next;
            rem_reg <= rem_next;
        end
    end

    assign busy = (step_reg != '0);
    assign remainder = rem_reg;

endmodule

>>> hdl/sender_selective_ack_window.sv
// Top level of the selective-repeat sender window: sequencer, window state
// and config registers. Depends on ssaw_pkg and ssaw_rem_unit.
//
// Usage:
//  - Input channel (in_valid/in_stall): kind 0 starts a transfer, kind 1
//    carries an ack for fragment acked_index. One transaction is taken at a
//    time; in_stall stays high while an item is being worked on.
//  - Output channel (out_valid/out_stall): one transaction per send request
//    (send_request=1), then one closing transaction with last=1 and the
//    status of the item. A one-entry output register sits between the
//    sequencer and the port, so results wait there while out_stall is high
//    and the sequencer simply holds its place.
//  - Steps from accept to the closing result: a dropped ack passes CHECK
//    and CLOSE; a completing ack CHECK, ADD, CMP and CLOSE; an accepted ack
//    also SLIDE, one slot per step, before CLOSE; a start passes START, one
//    send per step, then CLOSE. The next item is taken once the sequencer
//    is back in IDLE; output stalls add to this.
//  - Config writes to fragment_bytes or total_bytes restart the serial
//    remainder unit; in_stall is held until it finishes.
//  - Reset clears the window, the byte count, config registers to their
//    defaults and the output register.
module sender_selective_ack_window
    import ssaw_pkg::*;
#(
    parameter int WINDOW_SLOTS = WINDOW_SLOTS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // input channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  kind,
    input  logic [COUNT_W-1:0]    acked_index,
    // output channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  send_request,
    output logic [COUNT_W-1:0]    send_index,
    output logic [1:0]            status,
    output logic [TBYTES_W-1:0]   acked_bytes,
    output logic                  last
);

    localparam int OFF_W = $clog2(WINDOW_SLOTS);
    localparam int SLOT_CNT_W = $clog2(WINDOW_SLOTS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_CHECK,
        ST_ADD,
        ST_CMP,
        ST_SLIDE,
        ST_CLOSE
    } state_t;

    // config
    logic [COUNT_W-1:0]  frag_count_reg, frag_count_next;
    logic [FBYTES_W-1:0] frag_bytes_reg, frag_bytes_next;
    logic [TBYTES_W-1:0] total_bytes_reg, total_bytes_next;

    // sequencer and window state
    state_t                  state_reg, state_next;
    logic [COUNT_W-1:0]      idx_reg, idx_next;
    logic [COUNT_W-1:0]      base_reg, base_next;
    logic [WINDOW_SLOTS-1:0] ack_bits_reg, ack_bits_next;
    logic [TBYTES_W-1:0]     bytes_reg, bytes_next;
    logic                    done_reg, done_next;
    logic                    is_last_reg, is_last_next;
    logic [1:0]              item_status_reg, item_status_next;
    logic [SLOT_CNT_W-1:0]   slot_reg, slot_next;

    // output register
    logic                out_valid_reg, out_valid_next;
    logic                send_request_reg, send_request_next;
    logic [COUNT_W-1:0]  send_index_reg, send_index_next;
    logic [1:0]          status_reg, status_next;
    logic [TBYTES_W-1:0] acked_bytes_reg, acked_bytes_next;
    logic                last_reg, last_next;

    // remainder unit
    logic                rem_start;
    logic [TBYTES_W-1:0] rem_dividend;
    logic [FBYTES_W-1:0] rem_divisor;
    logic                rem_busy;
    logic [FBYTES_W-1:0] rem_value;

    // datapath
    logic                in_fire;
    logic                can_emit;
    logic [COUNT_W:0]    offset;
    logic                in_window;
    logic [OFF_W-1:0]    slot_off;
    logic [FBYTES_W-1:0] frag_len;
    logic [TBYTES_W:0]   byte_sum;
    logic [COUNT_W:0]    slide_frag;

    assign in_stall = (state_reg != ST_IDLE) || rem_busy;
    assign in_fire = in_valid && !in_stall;
    assign can_emit = !out_valid_reg || !out_stall;

    // new remainder whenever either operand is written
    assign rem_start = cfg_we
        && ((cfg_index == REG_FRAGMENT_BYTES) || (cfg_index == REG_TOTAL_BYTES));
    assign rem_dividend = (cfg_we && cfg_index == REG_TOTAL_BYTES)
        ? cfg_data[TBYTES_W-1:0] : total_bytes_reg;
    assign rem_divisor = (cfg_we && cfg_index == REG_FRAGMENT_BYTES)
        ? cfg_data[FBYTES_W-1:0] : frag_bytes_reg;

    ssaw_rem_unit u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (rem_start),
        .dividend  (rem_dividend),
        .divisor   (rem_divisor),
        .busy      (rem_busy),
        .remainder (rem_value)
    );

    // window test: idx - base without borrow and below the slot count
    assign offset = {1'b0, idx_reg} - {1'b0, base_reg};
    assign in_window = !offset[COUNT_W] && (offset[COUNT_W-1:0] < COUNT_W'(WINDOW_SLOTS));
    assign slot_off = offset[OFF_W-1:0];

    // short last fragment counts the remainder, a zero remainder a full one
    always_comb
    begin
        if (frag_bytes_reg == '0)
            frag_len = '0;
        else if (is_last_reg && rem_value != '0)
            frag_len = rem_value;
        else
            frag_len = frag_bytes_reg;
    end

    assign byte_sum = {1'b0, bytes_reg} + (TBYTES_W + 1)'(frag_len);
    assign slide_frag = {1'b0, base_reg} + (COUNT_W + 1)'(WINDOW_SLOTS);

    always_comb
    begin
        frag_count_next = frag_count_reg;
        frag_bytes_next = frag_bytes_reg;
        total_bytes_next = total_bytes_reg;
        state_next = state_reg;
        idx_next = idx_reg;
        base_next = base_reg;
        ack_bits_next = ack_bits_reg;
        bytes_next = bytes_reg;
        done_next = done_reg;
        is_last_next = is_last_reg;
        item_status_next = item_status_reg;
        slot_next = slot_reg;
        out_valid_next = out_valid_reg;
        send_request_next = send_request_reg;
        send_index_next = send_index_reg;
        status_next = status_reg;
        acked_bytes_next = acked_bytes_reg;
        last_next = last_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAGMENT_COUNT: frag_count_next = cfg_data[COUNT_W-1:0];
                REG_FRAGMENT_BYTES: frag_bytes_next = cfg_data[FBYTES_W-1:0];
                REG_TOTAL_BYTES:    total_bytes_next = cfg_data[TBYTES_W-1:0];
                default: ;
            endcase
        end

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    idx_next = acked_index;
                    if (kind == KIND_START)
                    begin
                        ack_bits_next = '0;
                        base_next = '0;
                        bytes_next = '0;
                        done_next = 1'b0;
                        slot_next = '0;
                        item_status_next = STATUS_STARTED;
                        state_next = ST_START;
                    end
                    else
                        state_next = ST_CHECK;
                end
            end

            ST_START:
            begin
                // fragments 0..W-1 that exist, while base is zero
                if (total_bytes_reg == '0 || slot_reg == SLOT_CNT_W'(WINDOW_SLOTS)
                    || COUNT_W'(slot_reg) >= frag_count_reg)
                    state_next = ST_CLOSE;
                else if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    send_request_next = 1'b1;
                    send_index_next = COUNT_W'(slot_reg);
                    status_next = item_status_reg;
                    acked_bytes_next = bytes_reg;
                    last_next = 1'b0;
                    slot_next = slot_reg + SLOT_CNT_W'(1);
                end
            end

            ST_CHECK:
            begin
                is_last_next = (({1'b0, idx_reg} + (COUNT_W + 1)'(1))
                    == {1'b0, frag_count_reg});
                if (done_reg || !in_window || ack_bits_reg[slot_off])
                begin
                    item_status_next = STATUS_DROPPED;
                    state_next = ST_CLOSE;
                end
                else
                begin
                    ack_bits_next[slot_off] = 1'b1;
                    state_next = ST_ADD;
                end
            end

            ST_ADD:
            begin
                bytes_next = byte_sum[TBYTES_W] ? BYTES_MAX : byte_sum[TBYTES_W-1:0];
                state_next = ST_CMP;
            end

            ST_CMP:
            begin
                if (bytes_reg >= total_bytes_reg)
                begin
                    done_next = 1'b1;
                    item_status_next = STATUS_COMPLETE;
                    state_next = ST_CLOSE;
                end
                else
                begin
                    item_status_next = STATUS_ACCEPTED;
                    state_next = ST_SLIDE;
                end
            end

            ST_SLIDE:
            begin
                // one slot per cycle while the output register can take a result; zeros shift in, so at most W steps
                if (!ack_bits_reg[0])
                    state_next = ST_CLOSE;
                else if (can_emit)
                begin
                    ack_bits_next = {1'b0, ack_bits_reg[WINDOW_SLOTS-1:1]};
                    base_next = base_reg + COUNT_W'(1);
                    if (slide_frag < {1'b0, frag_count_reg})
                    begin
                        out_valid_next = 1'b1;
                        send_request_next = 1'b1;
                        send_index_next = slide_frag[COUNT_W-1:0];
                        status_next = item_status_reg;
                        acked_bytes_next = bytes_reg;
                        last_next = 1'b0;
                    end
                end
            end

            ST_CLOSE:
            begin
                if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    send_request_next = 1'b0;
                    send_index_next = '0;
                    status_next = item_status_reg;
                    acked_bytes_next = bytes_reg;
                    last_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frag_count_reg <= '0;
            frag_bytes_reg <= FRAGMENT_BYTES_RST;
            total_bytes_reg <= '0;
            state_reg <= ST_IDLE;
            idx_reg <= '0;
            base_reg <= '0;
            ack_bits_reg <= '0;
            bytes_reg <= '0;
            done_reg <= 1'b0;
            is_last_reg <= 1'b0;
            item_status_reg <= STATUS_DROPPED;
            slot_reg <= '0;
            out_valid_reg <= 1'b0;
            send_request_reg <= 1'b0;
            send_index_reg <= '0;
            status_reg <= STATUS_DROPPED;
            acked_bytes_reg <= '0;
            last_reg <= 1'b0;
        end
        else
        begin
            frag_count_reg <= frag_count_next;
            frag_bytes_reg <= frag_bytes_next;
            total_bytes_reg <= total_bytes_next;
            state_reg <= state_next;
            idx_reg <= idx_next;
            base_reg <= base_next;
            ack_bits_reg <= ack_bits_next;
            bytes_reg <= bytes_next;
            done_reg <= done_next;
            is_last_reg <= is_last_next;
            item_status_reg <= item_status_next;
            slot_reg <= slot_next;
            out_valid_reg <= out_valid_next;
            send_request_reg <= send_request_next;
            send_index_reg <= send_index_next;
            status_reg <= status_next;
            acked_bytes_reg <= acked_bytes_next;
            last_reg <= last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign send_request = send_request_reg;
    assign send_index = send_index_reg;
    assign status = status_reg;
    assign acked_bytes = acked_bytes_reg;
    assign last = last_reg;

endmodule

>>> hdl/ssaw_checker.sv
// Port-level checker for the sender window, bound to the top level.
// Depends on ssaw_pkg for status codes and widths.
module ssaw_checker
    import ssaw_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input logic                send_request,
    input logic [COUNT_W-1:0]  send_index,
    input logic [1:0]          status,
    input logic [TBYTES_W-1:0] acked_bytes,
    input logic                last
);

    // a stalled transaction holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(send_request)
            && $stable(send_index) && $stable(status) && $stable(acked_bytes)
            && $stable(last))
        else $error("output changed while stalled");

    // an accepted item keeps the input side busy the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted while item in progress");

    // the closing transaction carries no send request
    a_close_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> !send_request && send_index == '0)
        else $error("closing transaction carries a send");

    // dropped and completed acks never request a send
    a_no_send_on_drop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STATUS_DROPPED || status == STATUS_COMPLETE)
            |-> !send_request && last)
        else $error("send on dropped or completing ack");

    // send requests never close an item
    a_send_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && send_request |-> !last)
        else $error("send marked last");

endmodule

bind sender_selective_ack_window ssaw_checker u_ssaw_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .send_request (send_request),
    .send_index   (send_index),
    .status       (status),
    .acked_bytes  (acked_bytes),
    .last         (last)
);

>>> tb/sender_selective_ack_window_tb.sv
// Self-checking testbench for sender_selective_ack_window: directed and random
// start/ack traffic with random idling on both channels, checked against a
// window predictor held in a scoreboard class. Depends on ssaw_pkg and sender_selective_ack_window.
module sender_selective_ack_window_tb
    import ssaw_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = WINDOW_SLOTS_DEF;
    localparam int OFF_BITS = $clog2(SLOTS);
    localparam int RANDOM_ITEMS = 200;

    // One output transaction, laid out field by field as on the ports.
    typedef struct packed {
        logic                send_request;
        logic [COUNT_W-1:0]  send_index;
        logic [1:0]          status;
        logic [TBYTES_W-1:0] acked_bytes;
        logic                last;
    } window_result_t;

    // Scoreboard: a private copy of the window and registers, advanced once
    // per accepted input transaction, plus the queue of results it implies.
    class window_scoreboard;
        logic [COUNT_W-1:0]  frag_count = '0;
        logic [FBYTES_W-1:0] frag_bytes = FRAGMENT_BYTES_RST;
        logic [TBYTES_W-1:0] total = '0;
        logic [SLOTS-1:0]    ack_bits = '0;
        logic [COUNT_W-1:0]  base = '0;
        logic [TBYTES_W-1:0] bytes_done = '0;
        bit                  window_done = 1'b0;
        window_result_t      expected_results[$];
        int                  errors = 0;

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            if (idx == REG_FRAGMENT_COUNT)
                frag_count = value[COUNT_W-1:0];
            else if (idx == REG_FRAGMENT_BYTES)
                frag_bytes = value[FBYTES_W-1:0];
            else if (idx == REG_TOTAL_BYTES)
                total = value[TBYTES_W-1:0];
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void push_result(logic req, logic [COUNT_W-1:0] idx, logic [1:0] st,
                                  logic lst);
            window_result_t r;
            r.send_request = req;
            r.send_index = idx;
            r.status = st;
            r.acked_bytes = bytes_done;
            r.last = lst;
            expected_results.push_back(r);
        endfunction

        // Bytes carried by fragment idx; the last one holds the remainder.
        function logic [31:0] fragment_length(logic [COUNT_W-1:0] idx);
            logic [31:0] rem;
            if (frag_bytes == 0)
                return 0;
            if ({1'b0, idx} + 33'd1 != {1'b0, frag_count})
                return 32'(frag_bytes);
            rem = 32'(total) % 32'(frag_bytes);
            return (rem == 0) ? 32'(frag_bytes) : rem;
        endfunction

        // Advance the window by one accepted input; returns its status.
        function logic [1:0] note_input(logic item_kind, logic [COUNT_W-1:0] idx);
            logic [COUNT_W:0] lo;
            logic [COUNT_W:0] hi;
            logic [COUNT_W:0] frag;
            logic [COUNT_W-1:0] offset;
            logic [31:0] sum;
            int k;
            if (item_kind == KIND_START) begin
                ack_bits = '0;
                base = '0;
                bytes_done = '0;
                window_done = 1'b0;
                if (total != 0) begin
                    for (k = 0; k < SLOTS; k++) begin
                        frag = 33'(k);
                        if (frag < {1'b0, frag_count})
                            push_result(1'b1, frag[COUNT_W-1:0], STATUS_STARTED, 1'b0);
                    end
                end
                push_result(1'b0, '0, STATUS_STARTED, 1'b1);
                return STATUS_STARTED;
            end
            lo = {1'b0, base};
            hi = lo + 33'(SLOTS);
            offset = idx - base;
            if (window_done || {1'b0, idx} < lo || {1'b0, idx} >= hi
                    || ack_bits[offset[OFF_BITS-1:0]]) begin
                push_result(1'b0, '0, STATUS_DROPPED, 1'b1);
                return STATUS_DROPPED;
            end
            ack_bits[offset[OFF_BITS-1:0]] = 1'b1;
            sum = 32'(bytes_done) + fragment_length(idx);
            bytes_done = (sum > 32'(BYTES_MAX)) ? BYTES_MAX : sum[TBYTES_W-1:0];
            if (bytes_done >= total) begin
                window_done = 1'b1;
                push_result(1'b0, '0, STATUS_COMPLETE, 1'b1);
                return STATUS_COMPLETE;
            end
            // slide past the contiguous acked run, one new fragment per slot
            for (k = 0; k < SLOTS && ack_bits[0]; k++) begin
                frag = {1'b0, base} + 33'(SLOTS);
                ack_bits = ack_bits >> 1;
                if (frag < {1'b0, frag_count})
                    push_result(1'b1, frag[COUNT_W-1:0], STATUS_ACCEPTED, 1'b0);
                base = base + 1;
            end
            push_result(1'b0, '0, STATUS_ACCEPTED, 1'b1);
            return STATUS_ACCEPTED;
        endfunction

        function void compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
            if (act_val !== exp_val) begin
                $error("%s: expected %0h, got %0h", name, exp_val, act_val);
                errors++;
            end
        endfunction

        function void check_result(window_result_t got);
            window_result_t want;
            if (expected_results.size() == 0) begin
                $error("unexpected result: send_request %0b send_index %0h status %0d",
                       got.send_request, got.send_index, got.status);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("send_request", 32'(want.send_request), 32'(got.send_request));
            compare_field("send_index", want.send_index, got.send_index);
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("acked_bytes", 32'(want.acked_bytes), 32'(got.acked_bytes));
            compare_field("last", 32'(want.last), 32'(got.last));
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic                  kind;
    logic [COUNT_W-1:0]    acked_index;
    logic                  out_valid;
    logic                  out_stall;
    logic                  send_request;
    logic [COUNT_W-1:0]    send_index;
    logic [1:0]            status;
    logic [TBYTES_W-1:0]   acked_bytes;
    logic                  last;

    window_scoreboard sb = new();
    bit quiet = 1'b0;       // no idling on either side while set
    int counted = 0;        // random input transactions sent

    sender_selective_ack_window u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .acked_index  (acked_index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .send_request (send_request),
        .send_index   (send_index),
        .status       (status),
        .acked_bytes  (acked_bytes),
        .last         (last)
    );

    always #2 clk = ~clk;

    // Idle length: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Register write; entered and left at a falling edge, block idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, value);
        @(negedge clk);
    endtask

    // One input transaction; waits for the handshake, then maybe idles.
    // in_valid is left high when no gap follows, so back-to-back items
    // never see it dropped and raised in one step.
    task automatic send_item(input logic item_kind, input logic [COUNT_W-1:0] item_index,
                             output logic [1:0] item_status);
        int gap;
        in_valid <= 1'b1;
        kind <= item_kind;
        acked_index <= item_index;
        do
            @(posedge clk);
        while (in_stall);
        item_status = sb.note_input(item_kind, item_index);
        @(negedge clk);
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Drain: hold the input off until every expected result is back,
    // then let the sequencer settle.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Random register set, mostly small transfers whose byte total is
    // consistent with count and length so completion is reachable.
    task automatic random_config();
        logic [31:0] cnt;
        logic [31:0] fb;
        logic [63:0] tot;
        int r;
        r = $urandom_range(0, 9);
        cnt = (r == 0) ? $urandom : $urandom_range(0, 40);
        r = $urandom_range(0, 9);
        fb = (r == 0) ? 32'd65535 : (r == 1) ? 32'd1 : $urandom_range(1, 300);
        r = $urandom_range(0, 9);
        if (r < 7 && cnt != 0 && cnt <= 40)
            tot = 64'(cnt - 1) * 64'(fb) + 64'($urandom_range(1, fb));
        else if (r < 9)
            tot = 64'($urandom_range(0, 12000));
        else
            tot = 64'($urandom & 32'(BYTES_MAX));
        if (tot > 64'(BYTES_MAX))
            tot = 64'(BYTES_MAX);
        if ($urandom_range(0, 9) < 8)
            write_reg(REG_FRAGMENT_COUNT, cnt);
        if ($urandom_range(0, 9) < 8)
            write_reg(REG_FRAGMENT_BYTES, fb);
        if ($urandom_range(0, 9) < 8)
            write_reg(REG_TOTAL_BYTES, tot[31:0]);
    endtask

    // Output side: check at the rising edge, pick the next stall at the
    // falling edge. Bursts of stall come from the same gap picker.
    initial begin
        int stall_left;
        stall_left = 0;
        out_stall = 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                sb.check_result({send_request, send_index, status, acked_bytes, last});
            @(negedge clk);
            if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else begin
                stall_left = pick_gap();
                out_stall <= (stall_left > 0);
                if (stall_left > 0)
                    stall_left--;
            end
        end
    end

    // Hard stop well past the slowest legal run.
    initial begin
        #4_000_000;
        $display("sender_selective_ack_window: mismatch");
        $finish;
    end

    initial begin
        logic [1:0] st;
        logic [COUNT_W-1:0] idx;
        int acks;
        int r;
        int n;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        kind = KIND_START;
        acked_index = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // --- directed ---
        // Reset defaults: empty transfer. Start sends nothing, the first ack
        // completes at once, a later ack is dropped after completion.
        send_item(KIND_START, 32'd0, st);
        send_item(KIND_ACK, 32'd0, st);
        send_item(KIND_ACK, 32'd0, st);
        wait_idle();

        // Five fragments of 100, short last one of 50.
        write_reg(REG_FRAGMENT_COUNT, 32'd5);
        write_reg(REG_FRAGMENT_BYTES, 32'd100);
        write_reg(REG_TOTAL_BYTES, 32'd450);
        send_item(KIND_START, 32'd0, st);
        send_item(KIND_ACK, 32'd1, st);            // out of order, no slide
        send_item(KIND_ACK, 32'd0, st);            // slides by two
        send_item(KIND_ACK, 32'd0, st);            // below the window
        send_item(KIND_ACK, 32'd18, st);           // past the window
        send_item(KIND_ACK, 32'd3, st);
        send_item(KIND_ACK, 32'd3, st);            // already marked
        send_item(KIND_ACK, 32'd2, st);
        send_item(KIND_ACK, 32'd4, st);            // last fragment, completes
        send_item(KIND_ACK, 32'd4, st);            // after completion
        wait_idle();

        // Zero fragment length: acks count nothing, window still slides.
        write_reg(REG_FRAGMENT_COUNT, 32'd40);
        write_reg(REG_FRAGMENT_BYTES, 32'd0);
        write_reg(REG_TOTAL_BYTES, 32'd1);
        send_item(KIND_START, 32'd0, st);
        send_item(KIND_ACK, 32'd0, st);
        wait_idle();

        // Largest register values.
        write_reg(REG_FRAGMENT_COUNT, 32'hFFFF_FFFF);
        write_reg(REG_FRAGMENT_BYTES, 32'd65535);
        write_reg(REG_TOTAL_BYTES, 32'(BYTES_MAX));
        send_item(KIND_START, 32'd0, st);
        send_item(KIND_ACK, 32'd0, st);
        send_item(KIND_ACK, 32'd15, st);
        send_item(KIND_ACK, 32'hFFFF_FFFF, st);
        wait_idle();

        // Remainder of zero: last fragment counts in full.
        write_reg(REG_FRAGMENT_COUNT, 32'd3);
        write_reg(REG_FRAGMENT_BYTES, 32'd7);
        write_reg(REG_TOTAL_BYTES, 32'd21);
        send_item(KIND_START, 32'd0, st);
        send_item(KIND_ACK, 32'd2, st);
        send_item(KIND_ACK, 32'd0, st);
        send_item(KIND_ACK, 32'd1, st);
        wait_idle();

        // --- random phases ---
        // Each phase: new registers, a start, then a run of acks that is
        // mostly inside the window, with noise and stray restarts.
        while (counted < RANDOM_ITEMS) begin
            random_config();
            quiet = ($urandom_range(0, 4) == 0);
            send_item(KIND_START, $urandom, st);
            counted++;
            n = $urandom_range(5, 60);
            acks = 0;
            while (acks < n && !sb.window_done && counted < RANDOM_ITEMS) begin
                if ($urandom_range(0, 99) < 8)
                    wait_idle();
                r = $urandom_range(0, 99);
                if (r < 45)
                    idx = sb.base;
                else if (r < 78)
                    idx = sb.base + $urandom_range(0, SLOTS - 1);
                else if (r < 86)
                    idx = $urandom;
                else if (r < 91)
                    idx = sb.base - 1;
                else if (r < 96)
                    idx = sb.base + SLOTS;
                else
                    idx = $urandom;
                if (r >= 96) begin
                    send_item(KIND_START, idx, st);
                end else begin
                    send_item(KIND_ACK, idx, st);
                    acks++;
                end
                counted++;
            end
            // a dropped ack after completion now and then
            if (sb.window_done && $urandom_range(0, 2) == 0)
                send_item(KIND_ACK, sb.base, st);
            wait_idle();
        end

        quiet = 1'b0;
        wait_idle();
        repeat (40) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("sender_selective_ack_window: match");
        else
            $display("sender_selective_ack_window: mismatch");
        $finish;
    end

endmodule

>>> filelist.f
hdl/ssaw_pkg.sv
hdl/ssaw_rem_unit.sv
hdl/sender_selective_ack_window.sv
hdl/ssaw_checker.sv
tb/sender_selective_ack_window_tb.sv
